[src/qsm_pkg.sv]
// Package for the quadrature speed meter.
// Holds event codes, register indexes, reset values and the speed scaling function.
// No dependencies.
package qsm_pkg;

  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 16;
  localparam int TICK_W     = 8;
  localparam int SCALE_W    = 16;
  localparam int SPEED_W    = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [KIND_W-1:0] KIND_EDGE_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q16    = 1'd1;

  localparam logic [TICK_W-1:0]  WINDOW_TICKS_RST = 8'd4;
  localparam logic [SCALE_W-1:0] SCALE_Q16_RST    = 16'd41615;

  typedef logic signed [COUNT_W-1:0] count_t;
  typedef logic signed [SPEED_W-1:0] speed_t;

  // Scale a signed count by scale/65536, truncate toward zero, saturate to a signed byte.
  function automatic speed_t scale_speed(input count_t raw, input logic [SCALE_W-1:0] scale);
    logic                       neg;
    logic [COUNT_W-1:0]         mag;
    logic [COUNT_W+SCALE_W-1:0] prod;
    logic [COUNT_W-1:0]         scaled;
    logic [SPEED_W-1:0]         sat;
    neg    = raw[COUNT_W-1];
    mag    = neg ? (~raw + 16'd1) : raw;
    prod   = {{SCALE_W{1'b0}}, mag} * {{COUNT_W{1'b0}}, scale};
    scaled = prod[COUNT_W+SCALE_W-1:SCALE_W];
    if (neg) begin
      sat = (scaled > 16'd128) ? 8'd128 : scaled[SPEED_W-1:0];
      return speed_t'(~sat + 8'd1);
    end
    sat = (scaled > 16'd127) ? 8'd127 : scaled[SPEED_W-1:0];
    return speed_t'(sat);
  endfunction

endpackage

[src/qsm_in_if.sv]
// Request channel of the quadrature speed meter: one encoder edge or timer tick.
// Depends on qsm_pkg.
interface qsm_in_if import qsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              level_a;
  logic              level_b;

  modport source (output valid, kind, level_a, level_b, input ready);
  modport sink   (input valid, kind, level_a, level_b, output ready);
endinterface

[src/qsm_out_if.sv]
// Result channel of the quadrature speed meter: speed, window status and pulse count.
// Depends on qsm_pkg.
interface qsm_out_if import qsm_pkg::*; ();
  logic   valid;
  logic   ready;
  speed_t speed_byte;
  logic   speed_new;
  logic   measuring;
  count_t pulse_count;

  modport source (output valid, speed_byte, speed_new, measuring, pulse_count, input ready);
  modport sink   (input valid, speed_byte, speed_new, measuring, pulse_count, output ready);
endinterface

[src/quadrature_speed_meter.sv]
// Top level of the quadrature speed meter: 4x decoder, tick-driven window and speed scaling.
// Depends on qsm_pkg, qsm_in_if and qsm_out_if.
//
// Each request (A edge, B edge or timer tick) yields exactly one result. A request is taken
// into an input register; from there its state update and result are computed in a
// single pass (decode step, tick compare, one 16x16 multiply with saturation) into the result
// register. Throughput is one request per cycle while the result side does not stall; the result
// register and the input register each hold a request while the result side stalls.
// Configuration writes take effect at once and are meant for idle periods.
module quadrature_speed_meter import qsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  qsm_in_if.sink                item,
  qsm_out_if.source             result
);

  logic [TICK_W-1:0]  window_ticks;
  logic [SCALE_W-1:0] scale_q16;

  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic              s1_level_a;
  logic              s1_level_b;

  count_t            pulse_counter, pulse_counter_next;
  logic              saved_a, saved_a_next;
  logic              saved_b, saved_b_next;
  logic [TICK_W-1:0] tick_counter, tick_counter_next;
  logic              window_open, window_open_next;
  speed_t            speed_reg, speed_reg_next;
  logic              fresh;

  logic              advance;
  logic [TICK_W-1:0] limit;
  logic              dir_up;

  assign advance    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_TICKS_RST;
      scale_q16    <= SCALE_Q16_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_WINDOW_TICKS: window_ticks <= wr_data[TICK_W-1:0];
        REG_SCALE_Q16:    scale_q16    <= wr_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_kind    <= item.kind;
      s1_level_a <= item.level_a;
      s1_level_b <= item.level_b;
    end
  end

  assign limit = (window_ticks == '0) ? TICK_W'(1) : window_ticks;

  always_comb begin
    pulse_counter_next = pulse_counter;
    saved_a_next       = saved_a;
    saved_b_next       = saved_b;
    tick_counter_next  = tick_counter;
    window_open_next   = window_open;
    speed_reg_next     = speed_reg;
    fresh              = 1'b0;
    dir_up             = 1'b0;
    case (s1_kind)
      KIND_EDGE_A: begin
        dir_up             = saved_a ^ saved_b;
        pulse_counter_next = dir_up ? pulse_counter + 16'sd1 : pulse_counter - 16'sd1;
        saved_a_next       = s1_level_a;
      end
      KIND_EDGE_B: begin
        saved_b_next       = s1_level_b;
        dir_up             = saved_a ^ s1_level_b;
        pulse_counter_next = dir_up ? pulse_counter + 16'sd1 : pulse_counter - 16'sd1;
      end
      KIND_TICK: begin
        if (tick_counter == limit) begin
          tick_counter_next = TICK_W'(1);
          window_open_next  = !window_open;
          if (!window_open) begin
            pulse_counter_next = '0;
          end else begin
            speed_reg_next = scale_speed(pulse_counter, scale_q16);
            fresh          = 1'b1;
          end
        end else begin
          tick_counter_next = tick_counter + TICK_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_counter <= '0;
      saved_a       <= 1'b0;
      saved_b       <= 1'b0;
      tick_counter  <= '0;
      window_open   <= 1'b0;
      speed_reg     <= '0;
    end else if (advance) begin
      pulse_counter <= pulse_counter_next;
      saved_a       <= saved_a_next;
      saved_b       <= saved_b_next;
      tick_counter  <= tick_counter_next;
      window_open   <= window_open_next;
      speed_reg     <= speed_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.speed_byte  <= speed_reg_next;
      result.speed_new   <= fresh;
      result.measuring   <= window_open_next;
      result.pulse_count <= pulse_counter_next;
    end
  end

endmodule
